### hw/rtl/bgu_pkg.sv
// ----------------------------------------------------------------------------
// bgu_pkg
// Shared widths, codes, types and helpers of the bilinear grid upscaler.
// ----------------------------------------------------------------------------
package bgu_pkg;

	// Fixed field widths
	localparam int SAMPLE_W   = 16;
	localparam int DROW_W     = 13;
	localparam int DCOL_W     = 8;
	localparam int ROWS_REG_W = 11;
	localparam int COLS_REG_W = 6;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 1;

	// Parameter defaults
	localparam int SCALE_DEF    = 5;
	localparam int MAX_COLS_DEF = 32;
	localparam int MAX_ROWS_DEF = 1024;

	// Register reset values
	localparam logic [ROWS_REG_W-1:0] SRC_ROWS_RST = ROWS_REG_W'(2);
	localparam logic [COLS_REG_W-1:0] SRC_COLS_RST = COLS_REG_W'(2);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_ROWS,
		REG_SRC_COLS
	} cfg_reg_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PREP,
		ST_EMIT
	} state_t;

	// Side information of one destination point
	typedef struct packed {
		logic [DROW_W-1:0] row;
		logic [DCOL_W-1:0] col;
		logic              last;
	} pt_meta_t;

	// Width of the signed blend numerator: |num| <= 32768*S^2, plus rounding
	// offset, plus sign.
	function automatic int num_width(input int scale);
		int sq;
		sq = scale * scale;
		return $clog2(32768 * sq + (sq >> 1) + 1) + 1;
	endfunction

endpackage

### hw/rtl/bgu_round_div.sv
// ----------------------------------------------------------------------------
// bgu_round_div
// Four-stage pipeline: divides the blend numerator by S^2 with rounding to
// nearest (ties away from zero) and holds the result transaction.
// ----------------------------------------------------------------------------
module bgu_round_div #(
	parameter int SCALE = bgu_pkg::SCALE_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             pt_valid,
	input  logic signed [bgu_pkg::num_width(SCALE)-1:0]      pt_num,
	input  bgu_pkg::pt_meta_t                                pt_meta,
	output logic                                             adv,
	output logic                                             result_valid,
	input  logic                                             result_stall,
	output logic        [bgu_pkg::DROW_W-1:0]                dest_row,
	output logic        [bgu_pkg::DCOL_W-1:0]                dest_col,
	output logic signed [bgu_pkg::SAMPLE_W-1:0]              value,
	output logic                                             last
);

	localparam int NUM_W = bgu_pkg::num_width(SCALE);
	localparam int MAG_W = NUM_W - 1;
	localparam int PW    = 2 * MAG_W;
	localparam int QW    = bgu_pkg::SAMPLE_W;
	localparam int SQ    = SCALE * SCALE;
	localparam int RW    = $clog2(2 * SQ);
	localparam logic [MAG_W-1:0] HALF  = MAG_W'(SQ / 2);
	localparam logic [MAG_W-1:0] RECIP = MAG_W'((longint'(1) << MAG_W) / longint'(SQ));

	logic                     v_s1, v_s2, v_s3, out_valid_q;
	logic                     neg_s1, neg_s2, neg_s3;
	logic [MAG_W-1:0]         mag_s1, mag_s2;
	logic [QW-1:0]            q_s2, q_s3;
	logic [RW-1:0]            rem_s3;
	bgu_pkg::pt_meta_t        meta_s1, meta_s2, meta_s3, meta_q;
	logic signed [QW-1:0]     value_q;
	logic [PW-1:0]            prod;
	logic [MAG_W-1:0]         rem_full;
	logic [QW-1:0]            q_fix;

	// Whole pipeline moves when the output register is free or being taken
	assign adv = !out_valid_q || !result_stall;

	assign prod     = PW'(mag_s1) * PW'(RECIP);
	assign rem_full = mag_s2 - MAG_W'(q_s2 * SQ);
	assign q_fix    = q_s3 + QW'(rem_s3 >= RW'(SQ));

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pt_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// Data stages
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: magnitude plus half divisor
			neg_s1  <= pt_num[NUM_W-1];
			mag_s1  <= MAG_W'(pt_num[NUM_W-1] ? -pt_num : pt_num) + HALF;
			meta_s1 <= pt_meta;
			// s2: reciprocal estimate, at most one low
			neg_s2  <= neg_s1;
			mag_s2  <= mag_s1;
			q_s2    <= prod[MAG_W +: QW];
			meta_s2 <= meta_s1;
			// s3: remainder
			neg_s3  <= neg_s2;
			q_s3    <= q_s2;
			rem_s3  <= RW'(rem_full);
			meta_s3 <= meta_s2;
			// output: correction and sign
			value_q <= $signed(neg_s3 ? -q_fix : q_fix);
			meta_q  <= meta_s3;
		end
	end

	assign result_valid = out_valid_q;
	assign dest_row     = meta_q.row;
	assign dest_col     = meta_q.col;
	assign value        = value_q;
	assign last         = meta_q.last;

`ifndef SYNTHESIS
	// Reciprocal estimate never more than one below the true quotient
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (rem_full < MAG_W'(2 * SQ)))
		else $error("reciprocal estimate out of range");

	// A held output freezes every stage
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({v_s1, v_s2, v_s3}))
		else $error("pipeline moved while output held");
`endif

endmodule

### hw/rtl/bgu_seq.sv
// ----------------------------------------------------------------------------
// bgu_seq
// Line buffer, position counters and point sequencer. A closing sample reads
// the two upper corners, sets up incremental blend terms and walks the cell's
// destination points, one numerator per cycle while the divider advances.
// ----------------------------------------------------------------------------
module bgu_seq #(
	parameter int SCALE    = bgu_pkg::SCALE_DEF,
	parameter int MAX_COLS = bgu_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = bgu_pkg::MAX_ROWS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_clear,
	input  logic        [$clog2(MAX_ROWS)-1:0]          rows_m1,
	input  logic        [$clog2(MAX_COLS)-1:0]          cols_m1,
	input  logic                                        sample_valid,
	output logic                                        sample_stall,
	input  logic signed [bgu_pkg::SAMPLE_W-1:0]         sample,
	input  logic                                        adv,
	output logic                                        pt_valid,
	output logic signed [bgu_pkg::num_width(SCALE)-1:0] pt_num,
	output bgu_pkg::pt_meta_t                           pt_meta
);

	localparam int NUM_W = bgu_pkg::num_width(SCALE);
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int DW    = $clog2(SCALE + 1);
	localparam int SW    = bgu_pkg::SAMPLE_W;
	localparam logic signed [NUM_W-1:0] S_S  = NUM_W'(SCALE);
	localparam logic signed [NUM_W-1:0] SQ_S = NUM_W'(SCALE * SCALE);

	bgu_pkg::state_t st_q, st_d;

	// Line buffer
	logic signed [SW-1:0] line_mem [MAX_COLS];
	logic signed [SW-1:0] rd_a_q, rd_b_q;
	logic                 mem_we;
	logic [COL_W-1:0]     mem_waddr;
	logic signed [SW-1:0] mem_wdata;

	// Position state
	logic [COL_W-1:0]     col_q, c_eff, c_q;
	logic [ROW_W-1:0]     row_q, r_eff, r_q;
	logic signed [SW-1:0] prev_q, p2_q, p3_q;
	logic                 close, close_q, c_last_q, r_last_q;
	logic                 accept, emit, pt_last;

	// Blend terms
	logic signed [NUM_W-1:0] p0w_q, d01_q, d02_q, dstep_q;
	logic signed [NUM_W-1:0] acc_q, rowbase_q, rowstep_q, diff_q;
	logic [DW-1:0]           dx_q, dy_q, dx_max, dy_max;
	logic [bgu_pkg::DROW_W-1:0] drow_q;
	logic [bgu_pkg::DCOL_W-1:0] dcol_q, col_base_q;

	// Current position, saturated into the grid
	assign c_eff  = (col_q > cols_m1) ? cols_m1 : col_q;
	assign r_eff  = (row_q > rows_m1) ? rows_m1 : row_q;
	assign close  = (c_eff != '0) && (r_eff != '0);

	assign sample_stall = (st_q != bgu_pkg::ST_IDLE);
	assign accept       = sample_valid && (st_q == bgu_pkg::ST_IDLE);

	assign dx_max  = c_last_q ? DW'(SCALE) : DW'(SCALE - 1);
	assign dy_max  = r_last_q ? DW'(SCALE) : DW'(SCALE - 1);
	assign pt_last = (dx_q == dx_max) && (dy_q == dy_max);
	assign pt_valid = (st_q == bgu_pkg::ST_EMIT);
	assign emit     = pt_valid && adv;
	assign pt_num   = acc_q;

	always_comb begin
		pt_meta.row  = drow_q;
		pt_meta.col  = dcol_q;
		pt_meta.last = pt_last;
	end

	// Next state and line buffer write port
	always_comb begin
		st_d      = st_q;
		mem_we    = 1'b0;
		mem_waddr = COL_W'(c_eff - 1'b1);
		mem_wdata = prev_q;
		case (st_q)
			bgu_pkg::ST_IDLE: begin
				if (accept) begin
					st_d   = bgu_pkg::ST_LOAD;
					mem_we = (c_eff != '0);
				end
			end
			bgu_pkg::ST_LOAD: begin
				// Last column also stores the new sample at its own slot
				mem_we    = c_last_q;
				mem_waddr = c_q;
				mem_wdata = p3_q;
				st_d      = close_q ? bgu_pkg::ST_PREP : bgu_pkg::ST_IDLE;
			end
			bgu_pkg::ST_PREP: begin
				st_d = bgu_pkg::ST_EMIT;
			end
			bgu_pkg::ST_EMIT: begin
				if (emit && pt_last) st_d = bgu_pkg::ST_IDLE;
			end
			default: begin
				st_d = bgu_pkg::ST_IDLE;
			end
		endcase
	end

	// Line buffer: reads return contents from before this cycle's write
	always_ff @(posedge clk) begin
		if (mem_we) line_mem[mem_waddr] <= mem_wdata;
		if (accept) begin
			rd_a_q <= line_mem[COL_W'(c_eff - 1'b1)];
			rd_b_q <= line_mem[c_eff];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= bgu_pkg::ST_IDLE;
			col_q  <= '0;
			row_q  <= '0;
			prev_q <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_clear) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				prev_q <= sample;
				if (c_eff == cols_m1) begin
					col_q <= '0;
					row_q <= (r_eff == rows_m1) ? '0 : ROW_W'(r_eff + 1'b1);
				end else begin
					col_q <= COL_W'(c_eff + 1'b1);
					row_q <= r_eff;
				end
			end
		end
	end

	// Cell setup and point walk
	always_ff @(posedge clk) begin
		case (st_q)
			bgu_pkg::ST_IDLE: begin
				if (accept) begin
					c_q      <= c_eff;
					r_q      <= r_eff;
					p2_q     <= prev_q;
					p3_q     <= sample;
					close_q  <= close;
					c_last_q <= (c_eff == cols_m1);
					r_last_q <= (r_eff == rows_m1);
				end
			end
			bgu_pkg::ST_LOAD: begin
				p0w_q   <= NUM_W'(rd_a_q);
				d01_q   <= NUM_W'(rd_b_q) - NUM_W'(rd_a_q);
				d02_q   <= NUM_W'(p2_q) - NUM_W'(rd_a_q);
				dstep_q <= NUM_W'(p3_q) - NUM_W'(rd_b_q) - NUM_W'(p2_q) + NUM_W'(rd_a_q);
			end
			bgu_pkg::ST_PREP: begin
				acc_q      <= p0w_q * SQ_S;
				rowbase_q  <= p0w_q * SQ_S;
				diff_q     <= d01_q * S_S;
				rowstep_q  <= d02_q * S_S;
				dx_q       <= '0;
				dy_q       <= '0;
				drow_q     <= bgu_pkg::DROW_W'((r_q - 1'b1) * SCALE);
				dcol_q     <= bgu_pkg::DCOL_W'((c_q - 1'b1) * SCALE);
				col_base_q <= bgu_pkg::DCOL_W'((c_q - 1'b1) * SCALE);
			end
			bgu_pkg::ST_EMIT: begin
				if (emit) begin
					if (dx_q == dx_max) begin
						dx_q      <= '0;
						dy_q      <= dy_q + 1'b1;
						rowbase_q <= rowbase_q + rowstep_q;
						acc_q     <= rowbase_q + rowstep_q;
						diff_q    <= diff_q + dstep_q;
						drow_q    <= drow_q + 1'b1;
						dcol_q    <= col_base_q;
					end else begin
						dx_q   <= dx_q + 1'b1;
						acc_q  <= acc_q + diff_q;
						dcol_q <= dcol_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	// Column position stays inside the configured grid
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= cols_m1)
		else $error("column counter outside grid");

	// A closing sample goes through the corner load and setup cycles
	a_close_seq: assert property (@(posedge clk) disable iff (!arst_n)
		accept && close |=> st_q == bgu_pkg::ST_LOAD ##1 st_q == bgu_pkg::ST_PREP)
		else $error("closing sample skipped setup");

	// The point marked last ends the walk
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit && pt_last |=> st_q == bgu_pkg::ST_IDLE)
		else $error("walk continued past last point");

	// Walk offsets never pass the cell edge
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid |-> (dx_q <= dx_max) && (dy_q <= dy_max))
		else $error("walk offset beyond cell");
`endif

endmodule

### hw/rtl/bilinear_grid_upscaler_unit.sv
// ----------------------------------------------------------------------------
// bilinear_grid_upscaler_unit
// Upsamples a row-major source grid by SCALE with bilinear blending in Q8.8.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                      payload
//  sample   in   sample_valid / sample_stall    sample
//  result   out  result_valid / result_stall    dest_row, dest_col, value, last
//  cfg      in   cfg_wen                        cfg_index, cfg_wdata
//
//  A closing sample holds the input through accept, ST_LOAD (corner read),
//  ST_PREP (setup) and the walk of SCALE^2 up to (SCALE+1)^2 points, one per
//  cycle unless the output stalls; others through accept and ST_LOAD, where
//  the last column also writes its sample to the line buffer. Results leave
//  a four-stage rounding divider; a stalled output holds the whole divider
//  and the walk. Reset clears counters, the previous sample, state and valid
//  registers; the line buffer is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module bilinear_grid_upscaler_unit #(
	parameter int SCALE    = bgu_pkg::SCALE_DEF,
	parameter int MAX_COLS = bgu_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = bgu_pkg::MAX_ROWS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [bgu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bgu_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [bgu_pkg::SAMPLE_W-1:0] sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [bgu_pkg::DROW_W-1:0]          dest_row,
	output logic [bgu_pkg::DCOL_W-1:0]          dest_col,
	output logic signed [bgu_pkg::SAMPLE_W-1:0] value,
	output logic                                last
);

	localparam int NUM_W = bgu_pkg::num_width(SCALE);
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS);

	logic [bgu_pkg::ROWS_REG_W-1:0] src_rows_q;
	logic [bgu_pkg::COLS_REG_W-1:0] src_cols_q;
	logic [ROW_W-1:0]               rows_m1;
	logic [COL_W-1:0]               cols_m1;
	logic                           adv, pt_valid;
	logic signed [NUM_W-1:0]        pt_num;
	bgu_pkg::pt_meta_t              pt_meta;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_rows_q <= bgu_pkg::SRC_ROWS_RST;
			src_cols_q <= bgu_pkg::SRC_COLS_RST;
		end else if (cfg_wen) begin
			case (bgu_pkg::cfg_reg_t'(cfg_index))
				bgu_pkg::REG_SRC_ROWS: src_rows_q <= cfg_wdata[bgu_pkg::ROWS_REG_W-1:0];
				bgu_pkg::REG_SRC_COLS: src_cols_q <= cfg_wdata[bgu_pkg::COLS_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Saturated grid size, kept as last index
	always_comb begin
		if (src_rows_q < bgu_pkg::ROWS_REG_W'(2))
			rows_m1 = ROW_W'(1);
		else if (src_rows_q > MAX_ROWS)
			rows_m1 = ROW_W'(MAX_ROWS - 1);
		else
			rows_m1 = ROW_W'(src_rows_q - 1'b1);

		if (src_cols_q < bgu_pkg::COLS_REG_W'(2))
			cols_m1 = COL_W'(1);
		else if (src_cols_q > MAX_COLS)
			cols_m1 = COL_W'(MAX_COLS - 1);
		else
			cols_m1 = COL_W'(src_cols_q - 1'b1);
	end

	bgu_seq #(
		.SCALE    (SCALE),
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_clear    (cfg_wen),
		.rows_m1      (rows_m1),
		.cols_m1      (cols_m1),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.adv          (adv),
		.pt_valid     (pt_valid),
		.pt_num       (pt_num),
		.pt_meta      (pt_meta)
	);

	bgu_round_div #(
		.SCALE (SCALE)
	) u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.pt_valid     (pt_valid),
		.pt_num       (pt_num),
		.pt_meta      (pt_meta),
		.adv          (adv),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.dest_row     (dest_row),
		.dest_col     (dest_col),
		.value        (value),
		.last         (last)
	);

endmodule
